@@ hdl/utf8_char_validate_decode_top_assert.svh @@
// ============================================================================
// utf8_char_validate_decode_top_assert.svh
// Assertion macros used by the checker file of the UTF-8 decoder
// ============================================================================
`ifndef UTF8_CHAR_VALIDATE_DECODE_TOP_ASSERT_SVH
`define UTF8_CHAR_VALIDATE_DECODE_TOP_ASSERT_SVH

// property must hold at every clock edge outside reset
`define UCVD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define UCVD_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ hdl/ucvd_pkg.sv @@
// ============================================================================
// ucvd_pkg
// Types and helpers shared by the UTF-8 validating decoder
// ============================================================================
package ucvd_pkg;

  // acceptance automaton states; lead state is implicit (first byte)
  typedef enum logic [3:0] {
    ST_TAIL1  = 4'd1,  // one continuation byte left, any 80..BF
    ST_E0     = 4'd2,  // after E0: needs A0..BF
    ST_GEN3   = 4'd3,  // after E1..EC, EE, EF, or 4-byte second byte
    ST_ED     = 4'd4,  // after ED: needs 80..9F (no surrogates)
    ST_F0     = 4'd5,  // after F0: needs 90..BF
    ST_GEN4   = 4'd6,  // after F1..F3
    ST_F4     = 4'd7,  // after F4: needs 80..8F
    ST_ACCEPT = 4'd8,
    ST_FAIL   = 4'd9
  } ucvd_st_t;

  // lead byte summary handed from the lead decoder to the pipeline
  typedef struct packed {
    ucvd_st_t   st;     // state after the lead byte
    logic [2:0] width;  // length announced by the lead byte
    logic [2:0] avail;  // available bytes, clamped to 1..4
  } ucvd_lead_t;

  localparam logic [7:0] CONT_MASK = 8'h3F;

  // next state after a continuation byte
  function automatic ucvd_st_t cont_next(input ucvd_st_t st, input logic [7:0] b);
    ucvd_st_t nxt;
    nxt = ST_FAIL;
    unique case (st)
      ST_TAIL1: if (b >= 8'h80 && b <= 8'hBF) nxt = ST_ACCEPT;
      ST_E0:    if (b >= 8'hA0 && b <= 8'hBF) nxt = ST_TAIL1;
      ST_GEN3:  if (b >= 8'h80 && b <= 8'hBF) nxt = ST_TAIL1;
      ST_ED:    if (b >= 8'h80 && b <= 8'h9F) nxt = ST_TAIL1;
      ST_F0:    if (b >= 8'h90 && b <= 8'hBF) nxt = ST_GEN3;
      ST_GEN4:  if (b >= 8'h80 && b <= 8'hBF) nxt = ST_GEN3;
      ST_F4:    if (b >= 8'h80 && b <= 8'h8F) nxt = ST_GEN3;
      default:  nxt = ST_FAIL;
    endcase
    return nxt;
  endfunction

endpackage

@@ hdl/ucvd_lead.sv @@
// ============================================================================
// ucvd_lead
// Lead byte decoder: first automaton step, announced length, clamped count
// ============================================================================
module ucvd_lead
  import ucvd_pkg::*;
(
  input  logic [7:0]  byte_0,
  input  logic [2:0]  avail_count,
  output ucvd_lead_t  lead
);

  always_comb begin
    // first automaton step on the lead byte
    unique case (byte_0) inside
      [8'h00:8'h7F]:               lead.st = ST_ACCEPT;
      [8'hC2:8'hDF]:               lead.st = ST_TAIL1;
      8'hE0:                       lead.st = ST_E0;
      8'hED:                       lead.st = ST_ED;
      [8'hE1:8'hEC], [8'hEE:8'hEF]: lead.st = ST_GEN3;
      8'hF0:                       lead.st = ST_F0;
      [8'hF1:8'hF3]:               lead.st = ST_GEN4;
      8'hF4:                       lead.st = ST_F4;
      default:                     lead.st = ST_FAIL;
    endcase

    // announced length, used only when the lead byte starts a multi-byte sequence
    if (byte_0 >= 8'hF0) begin
      lead.width = 3'd4;
    end else if (byte_0 >= 8'hE0) begin
      lead.width = 3'd3;
    end else if (byte_0 >= 8'hC0) begin
      lead.width = 3'd2;
    end else begin
      lead.width = 3'd1;
    end

    // zero counts as one, anything above four as four
    if (avail_count == 3'd0) begin
      lead.avail = 3'd1;
    end else if (avail_count > 3'd4) begin
      lead.avail = 3'd4;
    end else begin
      lead.avail = avail_count;
    end
  end

endmodule

@@ hdl/utf8_char_validate_decode_top.sv @@
// ============================================================================
// utf8_char_validate_decode_top
// Strict UTF-8 validating decoder, three-stage pipeline
// ============================================================================
// Usage: present up to four bytes starting at a candidate character on
// byte_0..byte_3 with avail_count (1..4) on the input channel. One result
// per transfer comes out on the output channel: scan_result 1..4 is the
// length of a valid character, 0 marks an invalid sequence, -1..-3 a cut
// short sequence with that many bytes missing. code_point holds the scalar
// value for a valid character and zero otherwise.
// Path: an input transfer is registered in stage 1, then stage 2, then
// the stage 3 output register, which drives out_valid.
// Throughput: one character per cycle while out_ready holds; stage 1
// decodes the lead byte, stage 2 runs the automaton over the continuation
// bytes, stage 3 assembles the code point and holds the output register.
// Each stage has its own valid bit and advances whenever it is empty or
// the next stage advances, so bubbles are squeezed out and a stalled
// receiver backs pressure up stage by stage with nothing lost or repeated.
// Reset clears all valid bits; no items are in flight afterwards.
// ============================================================================
module utf8_char_validate_decode_top
  import ucvd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         byte_0,
  input  logic [7:0]         byte_1,
  input  logic [7:0]         byte_2,
  input  logic [7:0]         byte_3,
  input  logic [2:0]         avail_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [3:0]  scan_result,
  output logic [20:0]        code_point
);

  // stage registers
  logic              v1, v2, v3;
  ucvd_lead_t        lead1;
  logic [3:0][7:0]   bytes1, bytes2;
  logic signed [3:0] res2;

  logic       rdy1, rdy2, rdy3;
  ucvd_lead_t lead_in;

  // per-stage advance: empty or the next stage moves
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  ucvd_lead u_lead (
    .byte_0      (byte_0),
    .avail_count (avail_count),
    .lead        (lead_in)
  );

  // stage 1: lead byte decode
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      lead1  <= lead_in;
      bytes1 <= {byte_3, byte_2, byte_1, byte_0};
    end
  end

  // stage 2 logic: walk the continuation bytes in order
  logic signed [3:0] res_next;
  always_comb begin
    ucvd_st_t st;
    logic     done;
    st       = lead1.st;
    done     = 1'b1;
    res_next = 4'sd0;
    if (st == ST_FAIL) begin
      res_next = 4'sd0;
    end else if (st == ST_ACCEPT) begin
      res_next = 4'sd1;
    end else if (lead1.avail <= 3'd1) begin
      res_next = 4'sd1 - $signed({1'b0, lead1.width});
    end else begin
      done = 1'b0;
    end
    for (int k = 1; k < 4; k++) begin
      if (!done) begin
        st = cont_next(st, bytes1[k]);
        if (st == ST_FAIL) begin
          res_next = 4'sd0;
          done     = 1'b1;
        end else if (st == ST_ACCEPT) begin
          res_next = 4'(k + 1);
          done     = 1'b1;
        end else if (32'(lead1.avail) <= k + 1) begin
          res_next = 4'(k + 1) - $signed({1'b0, lead1.width});
          done     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      res2   <= res_next;
      bytes2 <= bytes1;
    end
  end

  // stage 3 logic: assemble the scalar value
  logic [20:0] cp_next;
  always_comb begin
    case (res2)
      4'sd1:   cp_next = {13'd0, bytes2[0]};
      4'sd2:   cp_next = {10'd0, bytes2[0][4:0], bytes2[1][5:0]};
      4'sd3:   cp_next = {5'd0, bytes2[0][3:0], bytes2[1][5:0], bytes2[2][5:0]};
      4'sd4:   cp_next = {bytes2[0][2:0], bytes2[1][5:0], bytes2[2][5:0],
                          bytes2[3] [5:0] & CONT_MASK[5:0]};
      default: cp_next = 21'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      scan_result <= res2;
      code_point  <= cp_next;
    end
  end

  assign out_valid = v3;

endmodule

@@ hdl/ucvd_checker.sv @@
// ============================================================================
// ucvd_checker
// Port-level checks for the UTF-8 validating decoder, bound to the top level
// ============================================================================
`include "utf8_char_validate_decode_top_assert.svh"

module ucvd_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [3:0] scan_result,
  input logic [20:0]       code_point
);

  // no value unless the character is valid
  `UCVD_ASSERT(a_cp_zero, clk, rst, (out_valid && scan_result <= 4'sd0) |-> (code_point == 21'd0), "code point set on non-valid result")

  // result code stays within its defined range
  `UCVD_ASSERT_NEVER(a_res_range, clk, rst, out_valid && (scan_result > 4'sd4 || scan_result < -4'sd3), "scan result out of range")

  // three-byte characters are neither overlong nor surrogates
  `UCVD_ASSERT(a_cp3_legal, clk, rst, (out_valid && scan_result == 4'sd3) |-> (code_point >= 21'h000800 && code_point <= 21'h00FFFF && (code_point < 21'h00D800 || code_point > 21'h00DFFF)), "illegal three-byte value")

  // a stalled result holds
  `UCVD_ASSERT(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(scan_result) && $stable(code_point)), "stalled output changed")

endmodule

bind utf8_char_validate_decode_top ucvd_checker u_ucvd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .scan_result (scan_result),
  .code_point  (code_point)
);
